### design/csim_pkg.sv
// csim_pkg: shared types, constants and helpers for the cosine similarity core
// no dependencies; compiled first

package csim_pkg;

    localparam int DATA_W      = 16;
    localparam int SQ_W        = 40;
    localparam int DOT_W       = 41;
    localparam int ROOT_W      = 24;
    localparam int PROD_W      = 48;
    localparam int OPND_W      = 64;
    localparam int SQRT_STEPS  = 24;
    localparam int DIV_STEPS   = 64;
    localparam int CNT_W       = 7;
    localparam int MAX_LEN_DEF = 512;

    localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_AA,
        ACC_BB,
        ACC_AB,
        ACC_P,
        ACC_CLR
    } acc_op_t;

    typedef enum logic {
        SU_SQRT,
        SU_DIV
    } su_mode_t;

    typedef struct packed {
        logic     start;
        su_mode_t mode;
    } su_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } su_stat_t;

    // saturation level of the square sums
    function automatic logic [SQ_W-1:0] sq_cap_f(input int max_len);
        logic [OPND_W-1:0] full;
        full = OPND_W'(max_len) << 30;
        if (full < {{(OPND_W-SQ_W){1'b0}}, SQ_MAX})
            return full[SQ_W-1:0];
        else
            return SQ_MAX;
    endfunction

endpackage

### design/csim_if.sv
// csim_if: pair request and result channels of the cosine similarity core
// depends on csim_pkg

interface csim_pair_if import csim_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] elem_a;
    logic signed [DATA_W-1:0] elem_b;
    logic                     last_pair;

    modport source (output valid, elem_a, elem_b, last_pair, input ready);
    modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface csim_res_if import csim_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] similarity;
    logic                     zero_norm;

    modport source (output valid, similarity, zero_norm, input ready);
    modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

### design/csim_shift_sub.sv
// csim_shift_sub: iterative shift-subtract unit, floor square root or division
// depends on csim_pkg

module csim_shift_sub import csim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  su_cmd_t           cmd,
    input  logic [OPND_W-1:0] operand,
    input  logic [PROD_W-1:0] divisor,
    output su_stat_t          stat,
    output logic [OPND_W-1:0] result
);

    localparam int REM_W = PROD_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    su_mode_t          mode_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [OPND_W-1:0] src_reg;
    logic [OPND_W-1:0] res_reg;
    logic [PROD_W-1:0] div_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb
    begin
        if (mode_reg == SU_SQRT)
        begin
            rem_sh = {rem_reg[REM_W-3:0], src_reg[OPND_W-1 -: 2]};
            trial  = {{(REM_W-ROOT_W-2){1'b0}}, res_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[REM_W-2:0], src_reg[OPND_W-1]};
            trial  = {2'b00, div_reg};
        end
        ge = (rem_sh >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = (cmd.mode == SU_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= cmd.mode;
            rem_reg  <= '0;
            res_reg  <= '0;
            src_reg  <= operand;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - trial) : rem_sh;
            res_reg <= {res_reg[OPND_W-2:0], ge};
            src_reg <= (mode_reg == SU_SQRT) ? {src_reg[OPND_W-3:0], 2'b00}
                                             : {src_reg[OPND_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

### design/csim_acc.sv
// csim_acc: shared multiplier with saturating dot and square accumulators
// depends on csim_pkg

module csim_acc import csim_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  acc_op_t                  op,
    input  logic signed [DATA_W-1:0] elem_a,
    input  logic signed [DATA_W-1:0] elem_b,
    input  logic [ROOT_W-1:0]        ra,
    input  logic [ROOT_W-1:0]        rb,
    output logic [SQ_W-1:0]          sq_a,
    output logic [SQ_W-1:0]          sq_b,
    output logic signed [DOT_W-1:0]  dot,
    output logic [PROD_W-1:0]        prod
);

    localparam int MUL_W = ROOT_W + 1;
    localparam logic [SQ_W-1:0] SQ_CAP = sq_cap_f(MAX_LEN);

    logic [SQ_W-1:0]         sq_a_reg, sq_a_next;
    logic [SQ_W-1:0]         sq_b_reg, sq_b_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [PROD_W-1:0]       p_reg;

    logic signed [MUL_W-1:0]   mx, my;
    logic signed [2*MUL_W-1:0] mul;
    logic [SQ_W:0]             sq_sum_a, sq_sum_b, sq_inc;
    logic signed [DOT_W:0]     dot_sum, cap_pos, cap_neg;

    always_comb
    begin
        unique case (op)
            ACC_AA:
            begin
                mx = {{(MUL_W-DATA_W){elem_a[DATA_W-1]}}, elem_a};
                my = {{(MUL_W-DATA_W){elem_a[DATA_W-1]}}, elem_a};
            end
            ACC_BB:
            begin
                mx = {{(MUL_W-DATA_W){elem_b[DATA_W-1]}}, elem_b};
                my = {{(MUL_W-DATA_W){elem_b[DATA_W-1]}}, elem_b};
            end
            ACC_P:
            begin
                mx = {1'b0, ra};
                my = {1'b0, rb};
            end
            default:
            begin
                mx = {{(MUL_W-DATA_W){elem_a[DATA_W-1]}}, elem_a};
                my = {{(MUL_W-DATA_W){elem_b[DATA_W-1]}}, elem_b};
            end
        endcase
        mul = mx * my;
    end

    always_comb
    begin
        sq_inc   = {{(SQ_W-30){1'b0}}, mul[30:0]};
        sq_sum_a = {1'b0, sq_a_reg} + sq_inc;
        sq_sum_b = {1'b0, sq_b_reg} + sq_inc;
        dot_sum  = {dot_reg[DOT_W-1], dot_reg}
                 + {{(DOT_W-31){mul[31]}}, mul[31:0]};
        cap_pos  = {2'b00, SQ_CAP};
        cap_neg  = -cap_pos;

        sq_a_next = sq_a_reg;
        sq_b_next = sq_b_reg;
        dot_next  = dot_reg;
        unique case (op)
            ACC_AA:
                sq_a_next = (sq_sum_a > {1'b0, SQ_CAP}) ? SQ_CAP : sq_sum_a[SQ_W-1:0];
            ACC_BB:
                sq_b_next = (sq_sum_b > {1'b0, SQ_CAP}) ? SQ_CAP : sq_sum_b[SQ_W-1:0];
            ACC_AB:
            begin
                if (dot_sum > cap_pos)
                    dot_next = cap_pos[DOT_W-1:0];
                else if (dot_sum < cap_neg)
                    dot_next = cap_neg[DOT_W-1:0];
                else
                    dot_next = dot_sum[DOT_W-1:0];
            end
            ACC_CLR:
            begin
                sq_a_next = '0;
                sq_b_next = '0;
                dot_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_a_reg <= '0;
            sq_b_reg <= '0;
            dot_reg  <= '0;
        end
        else
        begin
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            dot_reg  <= dot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == ACC_P)
            p_reg <= mul[PROD_W-1:0];
    end

    assign sq_a = sq_a_reg;
    assign sq_b = sq_b_reg;
    assign dot  = dot_reg;
    assign prod = p_reg;

endmodule

### design/cosine_similarity_core.sv
// cosine_similarity_core: top level, sequencer around the accumulators and root/divide unit
// depends on csim_pkg, csim_if, csim_acc, csim_shift_sub

// Each element pair passes through one state to take the request and one for each of the
// three products, which share a single multiplier. After the pair marked last, the core
// works out the result: two 24-step square roots and a 64-step division through one
// shift-subtract unit, plus a multiply for the norm product; a zero square sum skips
// these. No pairs are taken while the result is worked out. The result sits in an output
// register, so the next vectors may stream in while it waits to be taken.

module cosine_similarity_core import csim_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    csim_pair_if.sink  pair,
    csim_res_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AA,
        S_BB,
        S_AB,
        S_FIN,
        S_SQA,
        S_SQB,
        S_MULP,
        S_DIVS,
        S_DIV,
        S_OUT
    } state_t;

    localparam logic [SQ_W-1:0] SQ_CAP = sq_cap_f(MAX_LEN);

    state_t                    state_reg, state_next;
    logic signed [DATA_W-1:0]  a_reg, a_next;
    logic signed [DATA_W-1:0]  b_reg, b_next;
    logic                      last_reg, last_next;
    logic [ROOT_W-1:0]         ra_reg, ra_next;
    logic [ROOT_W-1:0]         rb_reg, rb_next;
    logic signed [DATA_W-1:0]  pend_sim_reg, pend_sim_next;
    logic                      pend_zn_reg, pend_zn_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  sim_reg, sim_next;
    logic                      zn_reg, zn_next;

    acc_op_t                   acc_op;
    logic [SQ_W-1:0]           sq_a, sq_b;
    logic signed [DOT_W-1:0]   dot;
    logic [PROD_W-1:0]         prod;
    su_cmd_t                   su_cmd;
    su_stat_t                  su_stat;
    logic [OPND_W-1:0]         su_operand;
    logic [OPND_W-1:0]         su_result;
    logic [DOT_W-1:0]          dot_mag;
    logic                      slot_free;

    csim_acc #(
        .MAX_LEN (MAX_LEN)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (acc_op),
        .elem_a (a_reg),
        .elem_b (b_reg),
        .ra     (ra_reg),
        .rb     (rb_reg),
        .sq_a   (sq_a),
        .sq_b   (sq_b),
        .dot    (dot),
        .prod   (prod)
    );

    csim_shift_sub u_shift_sub (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (su_cmd),
        .operand (su_operand),
        .divisor (prod),
        .stat    (su_stat),
        .result  (su_result)
    );

    assign dot_mag   = dot[DOT_W-1] ? -dot : dot;
    assign slot_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        pend_sim_next  = pend_sim_reg;
        pend_zn_next   = pend_zn_reg;
        out_valid_next = out_valid_reg && !result.ready;
        sim_next       = sim_reg;
        zn_next        = zn_reg;
        acc_op         = ACC_NONE;
        su_cmd.start   = 1'b0;
        su_cmd.mode    = SU_SQRT;
        su_operand     = {sq_a, {(OPND_W-SQ_W){1'b0}}};

        unique case (state_reg)
            S_IDLE:
            begin
                if (pair.valid)
                begin
                    a_next     = pair.elem_a;
                    b_next     = pair.elem_b;
                    last_next  = pair.last_pair;
                    state_next = S_AA;
                end
            end
            S_AA:
            begin
                acc_op     = ACC_AA;
                state_next = S_BB;
            end
            S_BB:
            begin
                acc_op     = ACC_BB;
                state_next = S_AB;
            end
            S_AB:
            begin
                acc_op     = ACC_AB;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (sq_a == '0 || sq_b == '0)
                begin
                    pend_sim_next = '0;
                    pend_zn_next  = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    su_cmd.start = 1'b1;
                    state_next   = S_SQA;
                end
            end
            S_SQA:
            begin
                if (su_stat.done)
                begin
                    ra_next      = su_result[ROOT_W-1:0];
                    su_cmd.start = 1'b1;
                    su_operand   = {sq_b, {(OPND_W-SQ_W){1'b0}}};
                    state_next   = S_SQB;
                end
            end
            S_SQB:
            begin
                if (su_stat.done)
                begin
                    rb_next    = su_result[ROOT_W-1:0];
                    state_next = S_MULP;
                end
            end
            S_MULP:
            begin
                acc_op     = ACC_P;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                su_cmd.start = 1'b1;
                su_cmd.mode  = SU_DIV;
                su_operand   = {1'b0, dot_mag[SQ_W-1:0], 23'b0}
                             + {{(OPND_W-PROD_W+1){1'b0}}, prod[PROD_W-1:1]};
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                su_cmd.mode = SU_DIV;
                if (su_stat.done)
                begin
                    pend_zn_next = 1'b0;
                    if (dot[DOT_W-1])
                        pend_sim_next = (su_result > OPND_W'(32768))
                                      ? DATA_W'(16'sh8000)
                                      : -su_result[DATA_W-1:0];
                    else
                        pend_sim_next = (su_result > OPND_W'(32767))
                                      ? DATA_W'(16'sh7fff)
                                      : su_result[DATA_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sim_next       = pend_sim_reg;
                    zn_next        = pend_zn_reg;
                    acc_op         = ACC_CLR;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            ra_reg        <= '0;
            rb_reg        <= '0;
            pend_sim_reg  <= '0;
            pend_zn_reg   <= 1'b0;
            sim_reg       <= '0;
            zn_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            ra_reg        <= ra_next;
            rb_reg        <= rb_next;
            pend_sim_reg  <= pend_sim_next;
            pend_zn_reg   <= pend_zn_next;
            sim_reg       <= sim_next;
            zn_reg        <= zn_next;
        end
    end

    assign pair.ready        = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.similarity = sim_reg;
    assign result.zero_norm  = zn_reg;

`ifndef NO_ASSERTIONS
    a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !su_stat.busy)
        else $error("shift-subtract unit busy while taking pairs");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_op == ACC_CLR) |=> (sq_a == '0 && sq_b == '0 && dot == '0))
        else $error("accumulators not cleared after result");

    a_sq_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_a <= SQ_CAP) && (sq_b <= SQ_CAP))
        else $error("square sum above saturation level");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_norm) |-> (result.similarity == '0))
        else $error("zero norm result with nonzero similarity");
`endif

endmodule
